@@ design/bpfm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfm_pkg
// shared types and constants of the buffer pool frame manager
// ----------------------------------------------------------------------------
`default_nettype none

package bpfm_pkg;

    localparam int FRAMES   = 16;
    localparam int PIN_BITS = 8;
    localparam int FW       = $clog2(FRAMES);
    localparam int PAGE_W   = 32;

    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    // commands
    localparam logic [1:0] CMD_PIN   = 2'd0;
    localparam logic [1:0] CMD_UNPIN = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FRAME = 3'd1;
    localparam logic [2:0] ST_NOT_RES  = 3'd2;
    localparam logic [2:0] ST_PIN_ZERO = 3'd3;
    localparam logic [2:0] ST_PIN_LIM  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH_RD,
        S_FLUSH_WB,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        frame;
        logic              hit;
        logic              load_needed;
        logic              writeback_needed;
        logic [PAGE_W-1:0] writeback_page;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

@@ design/buffer_pool_frame_manager.sv @@
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager
// page frame pool with lru replacement, pin counts and dirty flush
// ----------------------------------------------------------------------------
// Page ids live in a synchronous memory with a registered read port, with a
// register copy for the parallel match; valid, pin count, dirty and the
// recency order are flip-flops. A hit pin or an unpin goes from accept to
// result through a registered match over the frames, then one update; a miss
// pin adds a state that reads the evicted page back from the memory. The
// result sits in an output register and the next beat is taken when it
// leaves. A flush walks the frames one per cycle, pausing at each dirty frame
// while its result is sent, and reads each dirty page from the memory, with
// one result per dirty frame and a closing result.
// No clearing pass is needed after reset.
`default_nettype none

module buffer_pool_frame_manager
    import bpfm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // s_axis_tdata: cmd[1:0], page_id[33:2], set_dirty[34], zero pad to 40
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    // m_axis_tdata: status[2:0], frame[6:3], hit[7], load_needed[8],
    // writeback_needed[9], writeback_page[41:10], zero pad to 48
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    t_state r_state, n_state;

    logic [PAGE_W-1:0]   mem_page [FRAMES];
    logic [PAGE_W-1:0]   r_rd_page;
    logic [FRAMES-1:0]   r_valid, r_dirty;
    logic [PIN_BITS-1:0] r_pin [FRAMES];
    logic [FW-1:0]       r_order [FRAMES];

    logic [1:0]          r_cmd;
    logic [PAGE_W-1:0]   r_page;
    logic                r_sdirty;
    logic [FRAMES-1:0]   r_match;
    logic [FW-1:0]       r_idx;
    t_result             r_res, n_res;
    logic                r_done;

    logic                in_beat, out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {6'd0, r_res.writeback_page, r_res.writeback_needed,
                            r_res.load_needed, r_res.hit, r_res.frame, r_res.status};
    assign m_axis_tlast  = r_res.last;

    // page id memory
    logic              mem_we;
    logic [FW-1:0]     mem_wa, mem_ra;
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_page[mem_wa] <= r_page;
        end
        r_rd_page <= mem_page[mem_ra];
    end

    // registered match of the incoming page against every frame
    logic [FRAMES-1:0] n_match;
    logic [PAGE_W-1:0] shadow [FRAMES];
    // page shadow for match; same content as the memory, per frame compare
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            shadow[mem_wa] <= r_page;
        end
    end
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            n_match[i] = r_valid[i] && (shadow[i] == s_axis_tdata[33:2]);
        end
    end

    // hit frame and victim selection
    logic          hit_any, vic_any;
    logic [FW-1:0] hit_f, vic_f;
    always_comb begin
        hit_any = 1'b0;
        hit_f   = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_any = 1'b1;
                hit_f   = FW'(i);
            end
        end
        vic_any = 1'b0;
        vic_f   = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (r_pin[r_order[i]] == '0) begin
                vic_any = 1'b1;
                vic_f   = r_order[i];
            end
        end
    end

    // recency move of one frame to the most recent slot
    logic          touch_en;
    logic [FW-1:0] touch_f;
    logic [FW-1:0] n_order [FRAMES];
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < FRAMES; i++) begin
            if (r_order[i] == touch_f) begin
                seen = 1'b1;
            end
            if (i == FRAMES - 1) begin
                n_order[i] = touch_f;
            end else begin
                n_order[i] = seen ? r_order[i+1] : r_order[i];
            end
        end
    end

    // next state and results
    logic pin_inc, pin_dec, set_d, clr_d, load_en;
    logic [FW-1:0] upd_f;
    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        mem_we   = 1'b0;
        mem_wa   = vic_f;
        mem_ra   = r_idx;
        touch_en = 1'b0;
        touch_f  = hit_f;
        pin_inc  = 1'b0;
        pin_dec  = 1'b0;
        set_d    = 1'b0;
        clr_d    = 1'b0;
        load_en  = 1'b0;
        upd_f    = hit_f;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_res.last = 1'b1;
                n_state = S_OUT;
                case (r_cmd)
                    CMD_PIN: begin
                        if (hit_any) begin
                            n_res.hit   = 1'b1;
                            n_res.frame = 4'(hit_f);
                            if (r_pin[hit_f] == PIN_MAX) begin
                                n_res.status = ST_PIN_LIM;
                            end else begin
                                pin_inc  = 1'b1;
                                touch_en = 1'b1;
                            end
                        end else if (vic_any) begin
                            n_res.frame       = 4'(vic_f);
                            n_res.load_needed = 1'b1;
                            n_res.writeback_needed = r_valid[vic_f] && r_dirty[vic_f];
                            mem_ra   = vic_f;
                            mem_we   = 1'b1;
                            load_en  = 1'b1;
                            upd_f    = vic_f;
                            touch_f  = vic_f;
                            touch_en = 1'b1;
                            n_state  = S_FLUSH_WB;
                        end else begin
                            n_res.status = ST_NO_FRAME;
                        end
                    end
                    CMD_UNPIN: begin
                        if (!hit_any) begin
                            n_res.status = ST_NOT_RES;
                        end else begin
                            n_res.frame = 4'(hit_f);
                            if (r_pin[hit_f] == '0) begin
                                n_res.status = ST_PIN_ZERO;
                            end else begin
                                pin_dec = 1'b1;
                                set_d   = r_sdirty;
                            end
                        end
                    end
                    CMD_FLUSH: begin
                        n_state = S_FLUSH_RD;
                    end
                    default: ;
                endcase
            end
            S_FLUSH_RD: begin
                // walk frames, read page of a dirty one
                upd_f = r_idx;
                if (r_done) begin
                    n_res      = '0;
                    n_res.last = 1'b1;
                    n_state    = S_OUT;
                end else if (r_valid[r_idx] && r_dirty[r_idx]) begin
                    clr_d   = 1'b1;
                    n_res   = '0;
                    n_res.frame = 4'(r_idx);
                    n_res.writeback_needed = 1'b1;
                    n_state = S_FLUSH_WB;
                end
            end
            S_FLUSH_WB: begin
                // page read back from memory lands here
                if (n_res.writeback_needed) begin
                    n_res.writeback_page = r_rd_page;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_beat) begin
                    n_state = (r_cmd == CMD_FLUSH && !r_res.last) ? S_FLUSH_RD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and frame table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_dirty <= '0;
            r_idx   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                r_pin[i]   <= '0;
                r_order[i] <= FW'(i);
            end
        end else begin
            r_state <= n_state;
            if (pin_inc) r_pin[upd_f] <= r_pin[upd_f] + 1'b1;
            if (pin_dec) r_pin[upd_f] <= r_pin[upd_f] - 1'b1;
            if (set_d)   r_dirty[upd_f] <= 1'b1;
            if (clr_d)   r_dirty[upd_f] <= 1'b0;
            if (load_en) begin
                r_valid[upd_f] <= 1'b1;
                r_pin[upd_f]   <= PIN_BITS'(1);
                r_dirty[upd_f] <= 1'b0;
            end
            if (touch_en) begin
                r_order <= n_order;
            end
            // flush frame walk
            if (in_beat) begin
                r_idx  <= '0;
                r_done <= 1'b0;
            end else if (r_state == S_FLUSH_RD && !r_done) begin
                if (r_idx == FW'(FRAMES - 1)) begin
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // beat capture and result register
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_cmd    <= s_axis_tdata[1:0];
            r_page   <= s_axis_tdata[33:2];
            r_sdirty <= s_axis_tdata[34];
            r_match  <= n_match;
        end
        r_res <= n_res;
    end

endmodule

`default_nettype wire

@@ design/bpfm_checker.sv @@
// ----------------------------------------------------------------------------
// bpfm_checker
// port level checks of the buffer pool frame manager
// ----------------------------------------------------------------------------
`default_nettype none

module bpfm_checker
    import bpfm_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // held result stays stable
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no new beat while a result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    // write-back page zero unless write-back flagged
    a_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[41:10] == '0)
        else $error("stray write-back page");

    // load only on a miss
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> !m_axis_tdata[7] && m_axis_tlast)
        else $error("load with hit");

endmodule

bind buffer_pool_frame_manager bpfm_checker u_bpfm_checker (.*);

`default_nettype wire
